// ----- hw/rtl/psqe_pkg.sv -----
// Package for the particle set query engine: widths, request codes, command/status types.
// No dependencies.
package psqe_pkg;
  localparam int MAX_PARTICLES_DEF = 1024;
  localparam int COORD_BITS_DEF    = 16;
  localparam int DENS_BITS = 16;
  localparam int HW_BITS   = 15;
  localparam int IDX_BITS  = 10;
  localparam int CNT_BITS  = 11;
  localparam int DIST_BITS = 34;
  localparam int SUM_BITS  = DENS_BITS + CNT_BITS;

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_LOAD  = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  typedef struct packed {
    logic clear;      // reset count and extremes
    logic load;       // append captured particle
    logic capture;    // capture the request item
    logic scan_start; // reset accumulators and scan pointer
    logic scan_step;  // issue one store read
    logic div_start;  // start mean divide
    logic div_step;   // one quotient bit
    logic out_load;   // latch result
  } psqe_cmd_t;

  typedef struct packed {
    logic empty;
    logic scan_last;  // last read issued
    logic div_done;
    logic pipe_idle;  // read pipeline drained
  } psqe_sts_t;
endpackage

// ----- hw/rtl/psqe_if.sv -----
// Valid/ready channel interfaces for request and result items.
// Depends on psqe_pkg.
interface psqe_req_if;
  import psqe_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] req_type;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic [15:0] density;
  logic [14:0] half_width;
  modport source (output valid, req_type, pos_x, pos_y, pos_z, density, half_width,
                  input ready);
  modport sink (input valid, req_type, pos_x, pos_y, pos_z, density, half_width,
                output ready);
endinterface

interface psqe_res_if;
  logic valid;
  logic ready;
  logic [9:0] nearest_index;
  logic [33:0] nearest_dist_sq;
  logic [10:0] in_area_count;
  logic [15:0] avg_density;
  logic signed [15:0] min_x;
  logic signed [15:0] min_y;
  logic signed [15:0] min_z;
  logic [15:0] extent_x;
  logic [15:0] extent_y;
  logic [15:0] extent_z;
  logic store_empty;
  modport source (output valid, nearest_index, nearest_dist_sq, in_area_count, avg_density,
                  min_x, min_y, min_z, extent_x, extent_y, extent_z, store_empty,
                  input ready);
  modport sink (input valid, nearest_index, nearest_dist_sq, in_area_count, avg_density,
                min_x, min_y, min_z, extent_x, extent_y, extent_z, store_empty,
                output ready);
endinterface

// ----- hw/rtl/psqe_datapath.sv -----
// Datapath: particle memory, extremes, scan pipeline, serial divider, result register.
// Depends on psqe_pkg, psqe_if.
module psqe_datapath
  import psqe_pkg::*;
#(
  parameter int MAX_PARTICLES = MAX_PARTICLES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  psqe_cmd_t cmd,
  output psqe_sts_t sts,
  psqe_req_if.sink req,
  psqe_res_if.source res
);
  localparam int AW  = $clog2(MAX_PARTICLES);
  localparam int PCW = $clog2(MAX_PARTICLES + 1);
  localparam int SW  = DENS_BITS + PCW;
  localparam int DBW = $clog2(SW + 1);
  localparam logic signed [15:0] CMAX = 16'sh7fff;
  localparam logic signed [15:0] CMIN = -16'sh8000;

  logic [63:0] mem [MAX_PARTICLES];
  logic [PCW-1:0] count;
  logic signed [15:0] low_x, low_y, low_z, high_x, high_y, high_z;
  logic signed [15:0] qx, qy, qz, ldens;
  logic [14:0] qhw;

  // scan pipeline
  logic [AW-1:0] rd_ptr;
  logic rd_v, st1_v, st2_v;
  logic [AW-1:0] rd_idx, st1_idx, st2_idx;
  logic [63:0] rd_data;
  logic signed [16:0] dx, dy, dz;
  logic [15:0] st1_dens;
  logic st1_in;
  logic [33:0] sq_x, sq_y, sq_z;
  logic [15:0] st2_dens;
  logic st2_in;
  logic [33:0] best_d;
  logic [AW-1:0] best_idx;
  logic best_v;
  logic [PCW-1:0] cnt;
  logic [SW-1:0] sum;

  // divider
  logic [SW-1:0] quo, rem_src;
  logic [PCW:0] rem;
  logic [DBW-1:0] div_bits;

  assign req.ready = cmd.capture;
  assign sts.empty = (count == '0);
  assign sts.scan_last = (PCW'(rd_ptr) == PCW'(count - 1'b1));
  assign sts.pipe_idle = !rd_v && !st1_v && !st2_v;
  assign sts.div_done = (div_bits == '0);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      qx <= req.pos_x; qy <= req.pos_y; qz <= req.pos_z;
      qhw <= req.half_width; ldens <= req.density;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count <= '0;
      low_x <= CMAX; low_y <= CMAX; low_z <= CMAX;
      high_x <= CMIN; high_y <= CMIN; high_z <= CMIN;
    end else if (cmd.load && count < PCW'(MAX_PARTICLES)) begin
      count <= count + 1'b1;
      if (qx < low_x) low_x <= qx;
      if (qy < low_y) low_y <= qy;
      if (qz < low_z) low_z <= qz;
      if (qx > high_x) high_x <= qx;
      if (qy > high_y) high_y <= qy;
      if (qz > high_z) high_z <= qz;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && count < PCW'(MAX_PARTICLES))
      mem[count[AW-1:0]] <= {qx, qy, qz, ldens};
    if (cmd.scan_step) rd_data <= mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0; st1_v <= 1'b0; st2_v <= 1'b0;
    end else begin
      rd_v <= cmd.scan_step; st1_v <= rd_v; st2_v <= st1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) rd_ptr <= '0;
    else if (cmd.scan_step) rd_ptr <= rd_ptr + 1'b1;
    rd_idx <= rd_ptr;
  end

  // stage 1: differences and cube test
  logic signed [15:0] cx, cy, cz;
  logic signed [16:0] hw17;
  assign cx = rd_data[63:48];
  assign cy = rd_data[47:32];
  assign cz = rd_data[31:16];
  assign hw17 = {2'b00, qhw};
  always_ff @(posedge clk) begin
    dx <= 17'(cx) - 17'(qx);
    dy <= 17'(cy) - 17'(qy);
    dz <= 17'(cz) - 17'(qz);
    st1_dens <= rd_data[15:0];
    st1_idx <= rd_idx;
    st1_in <= (18'(cx) > 18'(qx) - 18'(hw17)) && (18'(cx) < 18'(qx) + 18'(hw17)) &&
              (18'(cy) > 18'(qy) - 18'(hw17)) && (18'(cy) < 18'(qy) + 18'(hw17)) &&
              (18'(cz) > 18'(qz) - 18'(hw17)) && (18'(cz) < 18'(qz) + 18'(hw17));
  end

  // stage 2: squares
  always_ff @(posedge clk) begin
    sq_x <= 34'(dx * dx);
    sq_y <= 34'(dy * dy);
    sq_z <= 34'(dz * dz);
    st2_dens <= st1_dens;
    st2_in <= st1_in;
    st2_idx <= st1_idx;
  end

  // stage 3: accumulate
  logic [33:0] dsum;
  assign dsum = sq_x + sq_y + sq_z;
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      best_v <= 1'b0; cnt <= '0; sum <= '0;
      best_d <= '0; best_idx <= '0;
    end else if (st2_v) begin
      if (!best_v || dsum < best_d) begin
        best_d <= dsum; best_idx <= st2_idx;
      end
      best_v <= 1'b1;
      if (st2_in) begin
        cnt <= cnt + 1'b1;
        sum <= sum + SW'(st2_dens);
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [PCW:0] rem_sh;
  assign rem_sh = {rem[PCW-1:0], rem_src[SW-1]};
  always_ff @(posedge clk) begin
    if (rst) begin
      div_bits <= '0;
    end else if (cmd.div_start) begin
      div_bits <= DBW'(SW);
      rem_src <= sum; rem <= '0; quo <= '0;
    end else if (cmd.div_step && div_bits != '0) begin
      div_bits <= div_bits - 1'b1;
      rem_src <= rem_src << 1;
      if (rem_sh >= {1'b0, cnt}) begin
        rem <= rem_sh - {1'b0, cnt}; quo <= {quo[SW-2:0], 1'b1};
      end else begin
        rem <= rem_sh; quo <= {quo[SW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (sts.empty) begin
        res.nearest_index <= '0; res.nearest_dist_sq <= '0; res.in_area_count <= '0;
        res.avg_density <= '0; res.min_x <= '0; res.min_y <= '0; res.min_z <= '0;
        res.extent_x <= '0; res.extent_y <= '0; res.extent_z <= '0;
        res.store_empty <= 1'b1;
      end else begin
        res.nearest_index <= IDX_BITS'(best_idx);
        res.nearest_dist_sq <= best_d;
        res.in_area_count <= CNT_BITS'(cnt);
        res.avg_density <= (cnt == '0) ? '0 : quo[15:0];
        res.min_x <= low_x; res.min_y <= low_y; res.min_z <= low_z;
        res.extent_x <= 16'(high_x - low_x);
        res.extent_y <= 16'(high_y - low_y);
        res.extent_z <= 16'(high_z - low_z);
        res.store_empty <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) st2_v |-> !cmd.scan_start)
    else $error("scan restarted with reads in flight");
  assert property (@(posedge clk) disable iff (rst) cmd.div_start |=> !sts.div_done)
    else $error("divider did not start");
  assert property (@(posedge clk) disable iff (rst) sts.empty |-> !rd_v)
    else $error("read issued on empty store");
endmodule

// ----- hw/rtl/psqe_ctrl.sv -----
// Controller state machine: sequences clear, load, scan, divide and result handoff.
// Depends on psqe_pkg.
module psqe_ctrl
  import psqe_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic [1:0] req_type,
  input  logic res_ready,
  output logic res_valid,
  input  psqe_sts_t sts,
  output psqe_cmd_t cmd
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_DIV = 3'd4;
  localparam logic [2:0] S_OUT = 3'd5;

  logic [2:0] state, state_next;
  logic accept;

  assign accept = (state == S_IDLE) && req_valid;

  always_comb begin
    cmd = '0;
    state_next = state;
    res_valid = (state == S_OUT);
    case (state)
      S_IDLE: begin
        cmd.capture = 1'b1;
        if (req_valid) begin
          case (req_type)
            REQ_CLEAR: cmd.clear = 1'b1;
            REQ_LOAD:  state_next = S_LOAD;
            REQ_QUERY: begin
              cmd.scan_start = 1'b1;
              state_next = S_SCAN;
            end
            default: ;
          endcase
        end
      end
      S_LOAD: begin
        cmd.load = 1'b1;
        state_next = S_IDLE;
      end
      S_SCAN: begin
        if (sts.empty) begin
          cmd.out_load = 1'b1;
          state_next = S_OUT;
        end else begin
          cmd.scan_step = 1'b1;
          if (sts.scan_last) state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (sts.pipe_idle) begin
          cmd.div_start = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          cmd.out_load = 1'b1;
          state_next = S_OUT;
        end
      end
      S_OUT: if (res_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assert property (@(posedge clk) disable iff (rst) (res_valid && !res_ready) |=> res_valid)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst) accept |-> !res_valid)
    else $error("accept while result pending");
  assert property (@(posedge clk) disable iff (rst) $onehot0({cmd.load, cmd.scan_step,
    cmd.div_step, cmd.clear})) else $error("overlapping commands");
endmodule

// ----- hw/rtl/particle_set_query_engine.sv -----
// Top level of the particle set query engine: controller plus datapath.
// Depends on psqe_pkg, psqe_if, psqe_ctrl, psqe_datapath.
//
//  channel | dir | carries
//  req     | in  | req_type, pos_x/y/z, density, half_width
//  res     | out | nearest, in-cube count/mean, min/extent, empty flag
//
// Clear acts on acceptance; a load captures the particle on acceptance and appends
// it in S_LOAD. A query on N stored particles issues N store reads, one per cycle,
// drains the read register and the 3-stage scan pipeline, then runs a 27-step
// restoring divide for the mean density before the result load. A query on an
// empty store loads the result straight from the scan state. The single-port
// particle memory read sets the scan rate. Reset (rst, synchronous) empties the
// store. A waiting result holds until taken; no request is accepted meanwhile.
module particle_set_query_engine
  import psqe_pkg::*;
#(
  parameter int MAX_PARTICLES = MAX_PARTICLES_DEF
) (
  input logic clk,
  input logic rst,
  psqe_req_if.sink req,
  psqe_res_if.source res
);
  psqe_cmd_t cmd;
  psqe_sts_t sts;

  // sequence the work
  psqe_ctrl u_ctrl (
    .clk(clk), .rst(rst), .req_valid(req.valid), .req_type(req.req_type),
    .res_ready(res.ready), .res_valid(res.valid), .sts(sts), .cmd(cmd)
  );

  // hold store and compute results
  psqe_datapath #(.MAX_PARTICLES(MAX_PARTICLES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .req(req), .res(res)
  );
endmodule
